// File: rtl/core/uafn_pkg.sv
`default_nettype none

package uafn_pkg;

    // Reset value of the capacity register and default depth of the whitespace queue.
    localparam logic [15:0] UAFN_CAP_RESET     = 16'd256;
    localparam int          UAFN_PENDING_DEPTH = 16;

    // Lead byte classes of UTF-8.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    // Folding tables for U+00C0..U+00FF and U+0100..U+017F, first entry in the top byte.
    localparam logic [8*64-1:0] LATIN1_FOLD = {
        "AAAAAAECEEEEIIIIDNOOOOOxOUUUUYTs",
        "aaaaaaeceeeeiiiidnooooo/ouuuuyty"
    };
    localparam logic [8*128-1:0] EXT_A_FOLD = {
        "AaAaAaCcCcCcCcDdDdEeEeEeEeEeGgGg",
        "GgGgHhHhIiIiIiIiIiIiJjKkkLlLlLlL",
        "lLlNnNnNnnNnOoOoOoOoRrRrRrSsSsSs",
        "SsTtTtTtUuUuUuUuUuUuWwYyYZzZzZzs"
    };

    // Whitespace test: space and the controls from tab to carriage return.
    function automatic logic uafn_is_ws(input logic [7:0] b);
        return (b inside {8'h20, [8'h09:8'h0D]});
    endfunction

    // Fold a code point to lowercase ASCII; bit 7 of the result is set when it exists.
    function automatic logic [7:0] uafn_fold(input logic [20:0] cp);
        logic [7:0] ch;
        logic       ok;
        ch = 8'h00;
        ok = 1'b0;
        if (cp inside {[21'h0000C0:21'h0000FF]})
        begin
            ch = LATIN1_FOLD[8*(63 - int'(cp[5:0])) +: 8];
            ok = 1'b1;
        end
        else if (cp inside {[21'h000100:21'h00017F]})
        begin
            ch = EXT_A_FOLD[8*(127 - int'(cp[6:0])) +: 8];
            ok = 1'b1;
        end
        else if (cp < 21'h000080)
        begin
            ch = {1'b0, cp[6:0]};
            ok = 1'b1;
        end
        if (ok && (ch inside {[8'h41:8'h5A]}))
        begin
            ch = ch + 8'h20;
        end
        return {ok, ch[6:0]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/uafn_byte_if.sv
`default_nettype none

// Text byte channel.
interface uafn_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last_byte;

    modport source (output valid, output text_byte, output is_last_byte, input ready);
    modport sink   (input valid, input text_byte, input is_last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/core/uafn_char_if.sv
`default_nettype none

// Normalized character channel.
interface uafn_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       is_end;

    modport source (output valid, output out_char, output is_end, input ready);
    modport sink   (input valid, input out_char, input is_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/utf8_accent_fold_normalizer_top.sv
// Channel       Dir   Request payload
// text_stream   in    text_byte[7:0], is_last_byte
// char_stream   out   out_char[6:0], is_end
// cfg_we/wdata  in    output capacity, written when cfg_we is high
//
// A byte enters the input register and is worked off in steps; the next byte is
// taken as the last step of the current byte is done, so bytes can stream back to
// back. A non-space byte that follows held whitespace takes an extra step for each
// queued whitespace byte and for a held character; a whitespace byte that meets a
// full queue takes an extra step when a character is held; the last byte of a text
// takes a further step for the terminator. The output register lets the next byte
// in while a result waits, and a stalled output holds the work.
// Reset clears all control state and sets the capacity to 256.
`default_nettype none

module utf8_accent_fold_normalizer_top
    import uafn_pkg::*;
#(
    parameter int PENDING_SPACE_DEPTH = UAFN_PENDING_DEPTH
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [15:0] cfg_wdata,
    uafn_byte_if.sink   text_stream,
    uafn_char_if.source char_stream
);

    localparam int PW = (PENDING_SPACE_DEPTH > 1) ? $clog2(PENDING_SPACE_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_SPACE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(PENDING_SPACE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR  = PW'(PENDING_SPACE_DEPTH - 1);

    // Configuration and per-text state.
    logic [15:0]   cap_reg;
    logic          seen_reg,    seen_next;
    logic [1:0]    need_reg,    need_next;
    logic [20:0]   pcp_reg,     pcp_next;
    logic [7:0]    held_reg,    held_next;
    logic [CW-1:0] cnt_reg,     cnt_next;
    logic [PW-1:0] head_reg,    head_next;
    logic [PW-1:0] tail_reg,    tail_next;
    logic [15:0]   written_reg, written_next;
    logic          term_reg,    term_next;

    // Input register and output register.
    logic       cur_valid_reg;
    logic [7:0] cur_byte_reg;
    logic       cur_last_reg;
    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       out_end_reg;

    // Whitespace queue and its prefetched head entry.
    logic [6:0]    pend_mem [PENDING_SPACE_DEPTH];
    logic [6:0]    rd_data_reg;
    logic [PW-1:0] head_eff;
    logic          wr_en;

    logic          step_go;
    logic          accept;
    logic          cur_ws;
    logic          emit_req;
    logic [6:0]    emit_char;
    logic          emit_end;
    logic          push;
    logic          finish;
    logic          item_done;
    logic [7:0]    fold_res;
    logic [20:0]   pcp_shift;
    logic [15:0]   cap_lim;
    logic          cap_ok;
    logic          out_load;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] tail_inc;

    // Handshake and capacity limit.
    assign step_go  = cur_valid_reg && (!out_valid_reg || char_stream.ready);
    assign accept   = text_stream.valid && text_stream.ready;
    assign cur_ws   = uafn_is_ws(cur_byte_reg);
    assign cap_lim  = (cap_reg == 16'd0) ? 16'd0 : cap_reg - 16'd1;
    assign cap_ok   = written_reg < cap_lim;
    assign head_inc = (head_reg == LAST_PTR) ? '0 : head_reg + PW'(1);
    assign tail_inc = (tail_reg == LAST_PTR) ? '0 : tail_reg + PW'(1);
    assign out_load = step_go && emit_req && (emit_end || cap_ok);
    assign head_eff = step_go ? head_next : head_reg;
    assign wr_en    = step_go && push;

    assign text_stream.ready    = !cur_valid_reg || (step_go && item_done);
    assign char_stream.valid    = out_valid_reg;
    assign char_stream.out_char = out_char_reg;
    assign char_stream.is_end   = out_end_reg;

    // One step of work on the byte in the input register.
    always_comb
    begin
        seen_next = seen_reg;
        need_next = need_reg;
        pcp_next  = pcp_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        term_next = term_reg;
        emit_req  = 1'b0;
        emit_char = 7'd0;
        emit_end  = 1'b0;
        push      = 1'b0;
        finish    = 1'b0;
        item_done = 1'b0;
        fold_res  = 8'd0;
        pcp_shift = {pcp_reg[14:0], cur_byte_reg[5:0]};

        if (term_reg)
        begin
            // Terminator, then the text state returns to reset.
            emit_req  = 1'b1;
            emit_end  = 1'b1;
            item_done = 1'b1;
            seen_next = 1'b0;
            need_next = 2'd0;
            pcp_next  = '0;
            held_next = '0;
            cnt_next  = '0;
            head_next = '0;
            tail_next = '0;
            term_next = 1'b0;
        end
        else if (need_reg != 2'd0)
        begin
            // Continuation byte: any value, low six bits only.
            need_next = need_reg - 2'd1;
            pcp_next  = pcp_shift;
            if (need_reg == 2'd1)
            begin
                fold_res = uafn_fold(pcp_shift);
                if (fold_res[7])
                begin
                    if (cur_ws)
                    begin
                        held_next = fold_res;
                    end
                    else
                    begin
                        emit_req  = 1'b1;
                        emit_char = fold_res[6:0];
                    end
                end
                pcp_next = '0;
            end
            finish = 1'b1;
        end
        else if (cur_ws)
        begin
            // Whitespace after text is queued; a full queue flushes its oldest entry.
            if (!seen_reg)
            begin
                finish = 1'b1;
            end
            else if (cnt_reg == DEPTH_CNT)
            begin
                if (held_reg[7])
                begin
                    emit_req  = 1'b1;
                    emit_char = held_reg[6:0];
                    held_next = '0;
                end
                else
                begin
                    emit_req  = 1'b1;
                    emit_char = rd_data_reg;
                    head_next = head_inc;
                    push      = 1'b1;
                    tail_next = tail_inc;
                    finish    = 1'b1;
                end
            end
            else
            begin
                push      = 1'b1;
                tail_next = tail_inc;
                cnt_next  = cnt_reg + CW'(1);
                finish    = 1'b1;
            end
        end
        else
        begin
            // Confirming byte: held character, queued whitespace, then its own result.
            if (held_reg[7])
            begin
                emit_req  = 1'b1;
                emit_char = held_reg[6:0];
                held_next = '0;
            end
            else if (cnt_reg != '0)
            begin
                emit_req  = 1'b1;
                emit_char = rd_data_reg;
                head_next = head_inc;
                cnt_next  = cnt_reg - CW'(1);
            end
            else
            begin
                seen_next = 1'b1;
                finish    = 1'b1;
                if (!cur_byte_reg[7])
                begin
                    fold_res  = uafn_fold({13'd0, cur_byte_reg});
                    emit_req  = 1'b1;
                    emit_char = fold_res[6:0];
                end
                else if ((cur_byte_reg & LEAD2_MASK) == LEAD2_CODE)
                begin
                    need_next = 2'd1;
                    pcp_next  = {16'd0, cur_byte_reg[4:0]};
                end
                else if ((cur_byte_reg & LEAD3_MASK) == LEAD3_CODE)
                begin
                    need_next = 2'd2;
                    pcp_next  = {17'd0, cur_byte_reg[3:0]};
                end
                else if ((cur_byte_reg & LEAD4_MASK) == LEAD4_CODE)
                begin
                    need_next = 2'd3;
                    pcp_next  = {18'd0, cur_byte_reg[2:0]};
                end
                else
                begin
                    fold_res = uafn_fold({13'd0, cur_byte_reg});
                    if (fold_res[7])
                    begin
                        emit_req  = 1'b1;
                        emit_char = fold_res[6:0];
                    end
                end
            end
        end

        // The last byte of a text is followed by a terminator step.
        if (finish)
        begin
            if (cur_last_reg)
            begin
                term_next = 1'b1;
            end
            else
            begin
                item_done = 1'b1;
            end
        end
    end

    // Character count against the capacity.
    always_comb
    begin
        written_next = written_reg;
        if (term_reg)
        begin
            written_next = '0;
        end
        else if (emit_req && cap_ok)
        begin
            written_next = written_reg + 16'd1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= UAFN_CAP_RESET;
            seen_reg      <= 1'b0;
            need_reg      <= 2'd0;
            pcp_reg       <= '0;
            held_reg      <= '0;
            cnt_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            written_reg   <= '0;
            term_reg      <= 1'b0;
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (step_go)
            begin
                seen_reg    <= seen_next;
                need_reg    <= need_next;
                pcp_reg     <= pcp_next;
                held_reg    <= held_next;
                cnt_reg     <= cnt_next;
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                written_reg <= written_next;
                term_reg    <= term_next;
            end
            if (accept)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (step_go && item_done)
            begin
                cur_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (char_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_byte_reg <= text_stream.text_byte;
            cur_last_reg <= text_stream.is_last_byte;
        end
        if (out_load)
        begin
            out_char_reg <= emit_char;
            out_end_reg  <= emit_end;
        end
    end

    // Whitespace queue: one write port, registered read of the next head entry.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pend_mem[tail_reg] <= cur_byte_reg[6:0];
        end
        if (wr_en && (tail_reg == head_eff))
        begin
            rd_data_reg <= cur_byte_reg[6:0];
        end
        else
        begin
            rd_data_reg <= pend_mem[head_eff];
        end
    end

    // The queue pointers meet only when it is empty or full.
    a_ptr_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == tail_reg) |-> (cnt_reg == '0 || cnt_reg == DEPTH_CNT))
        else $error("queue pointers meet with a partial count");

    // A held character only exists after a non-space byte of the text.
    a_held_seen: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg[7] |-> seen_reg)
        else $error("held character without a prior non-space byte");

    // The terminator step leaves the text state cleared.
    a_term_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step_go && term_reg) |=>
            (cnt_reg == '0 && !seen_reg && written_reg == '0 && !held_reg[7]))
        else $error("text state not cleared after terminator");

endmodule

`default_nettype wire
